/* sv/tier0_message_decoder_assert.svh */
// Assertion macros used by the decoder checker.
`ifndef TIER0_MESSAGE_DECODER_ASSERT_SVH
`define TIER0_MESSAGE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define T0MD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define T0MD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/t0md_pkg.sv */
// Shared types, codes and kind tables of the message decoder.
package t0md_pkg;

   localparam int MsgBytes = 17;
   localparam int MsgBits  = 8 * MsgBytes;

   typedef enum logic [1:0] {
      StOk       = 2'd0,
      StTrunc    = 2'd1,
      StUnsup    = 2'd2,
      StNoncanon = 2'd3
   } status_type;

   typedef logic [2:0] kind_type;

   localparam kind_type KindPresence  = 3'd0;
   localparam kind_type KindHazard    = 3'd1;
   localparam kind_type KindRequest   = 3'd2;
   localparam kind_type KindAuthority = 3'd3;
   localparam kind_type KindDegraded  = 3'd4;
   localparam kind_type KindOffer     = 3'd5;
   localparam kind_type KindAccept    = 3'd6;

   localparam logic CsrExpectedMajor  = 1'b0;
   localparam logic CsrAllowExtension = 1'b1;

   typedef struct packed {
      status_type         status;
      kind_type           kind;
      logic [1:0]         prio;
      logic [4:0]         len;
      logic [MsgBits-1:0] msg;
   } entry_type;

   typedef struct packed {
      logic     found;
      kind_type kind;
   } lookup_type;

   function automatic lookup_type kind_lookup(input logic [3:0] cat, input logic [4:0] op);
      lookup_type r;
      r.found = 1'b1;
      r.kind  = KindPresence;
      unique case ({cat, op})
         {4'd0, 5'd0}: r.kind = KindPresence;
         {4'd3, 5'd1}: r.kind = KindHazard;
         {4'd5, 5'd1}: r.kind = KindRequest;
         {4'd1, 5'd1}: r.kind = KindAuthority;
         {4'd6, 5'd1}: r.kind = KindDegraded;
         {4'd8, 5'd0}: r.kind = KindOffer;
         {4'd8, 5'd1}: r.kind = KindAccept;
         default:      r.found = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] kind_length(input kind_type k);
      logic [4:0] r;
      unique case (k)
         KindPresence:  r = 5'd11;
         KindHazard:    r = 5'd15;
         KindRequest:   r = 5'd17;
         KindAuthority: r = 5'd14;
         KindDegraded:  r = 5'd10;
         KindOffer:     r = 5'd17;
         default:       r = 5'd16;
      endcase
      return r;
   endfunction

   // Number of body fields; the source reference comes on top.
   function automatic logic [3:0] kind_fields(input kind_type k);
      logic [3:0] r;
      unique case (k)
         KindPresence:  r = 4'd3;
         KindHazard:    r = 4'd8;
         KindRequest:   r = 4'd6;
         KindOffer:     r = 4'd5;
         default:       r = 4'd4;
      endcase
      return r;
   endfunction

   // Padding bits all sit in the low end of the final byte.
   function automatic logic [7:0] pad_mask(input kind_type k);
      logic [7:0] r;
      unique case (k)
         KindHazard:    r = 8'h03;
         KindRequest:   r = 8'h3f;
         KindAuthority: r = 8'h3f;
         KindDegraded:  r = 8'h3f;
         default:       r = 8'h00;
      endcase
      return r;
   endfunction

   // Byte 0 occupies the top bits of msg, MSB first.
   function automatic logic [31:0] field_value(input kind_type k, input logic [3:0] idx,
                                               input logic [MsgBits-1:0] msg);
      logic [31:0] r;
      r = 32'd0;
      if (idx == 4'd0) begin
         r = msg[119:88];
      end else begin
         unique case (k)
            KindPresence: begin
               case (idx)
                  4'd1:    r = 32'(msg[87:80]);
                  4'd2:    r = 32'(msg[79:56]);
                  4'd3:    r = 32'(msg[55:48]);
                  default: r = 32'd0;
               endcase
            end
            KindHazard: begin
               case (idx)
                  4'd1:    r = 32'(msg[87:80]);
                  4'd2:    r = 32'(msg[79:77]);
                  4'd3:    r = 32'(msg[76:70]);
                  4'd4:    r = {{20{msg[69]}}, msg[69:58]};
                  4'd5:    r = {{20{msg[57]}}, msg[57:46]};
                  4'd6:    r = {{22{msg[45]}}, msg[45:36]};
                  4'd7:    r = 32'(msg[35:26]);
                  4'd8:    r = 32'(msg[25:18]);
                  default: r = 32'd0;
               endcase
            end
            KindRequest: begin
               case (idx)
                  4'd1:    r = 32'(msg[87:80]);
                  4'd2:    r = msg[79:48];
                  4'd3:    r = {{20{msg[47]}}, msg[47:36]};
                  4'd4:    r = {{20{msg[35]}}, msg[35:24]};
                  4'd5:    r = 32'(msg[23:14]);
                  4'd6:    r = 32'(msg[13:6]);
                  default: r = 32'd0;
               endcase
            end
            KindAuthority: begin
               case (idx)
                  4'd1:    r = 32'(msg[87:82]);
                  4'd2:    r = 32'(msg[81:70]);
                  4'd3:    r = msg[69:38];
                  4'd4:    r = 32'(msg[37:30]);
                  default: r = 32'd0;
               endcase
            end
            KindDegraded: begin
               case (idx)
                  4'd1:    r = 32'(msg[87:80]);
                  4'd2:    r = 32'(msg[79:73]);
                  4'd3:    r = 32'(msg[72:70]);
                  4'd4:    r = 32'(msg[69:62]);
                  default: r = 32'd0;
               endcase
            end
            default: begin
               case (idx)
                  4'd1:    r = msg[87:56];
                  4'd2:    r = 32'(msg[55:48]);
                  4'd3:    r = 32'(msg[47:40]);
                  4'd4:    r = msg[39:8];
                  4'd5:    r = 32'(msg[7:0]);
                  default: r = 32'd0;
               endcase
            end
         endcase
      end
      return r;
   endfunction

endpackage

/* sv/t0md_fifo.sv */
// Short queue of classified messages between the front and back parts.
module t0md_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  t0md_pkg::entry_type push_entry,
   input  logic                pop,
   output t0md_pkg::entry_type head,
   output logic                empty,
   output logic                full
);
   localparam int Depth = 4;

   t0md_pkg::entry_type mem_ff [Depth];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == 3'd0);
   assign full  = (cnt_ff == 3'(Depth));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(push);
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      cnt_in    = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

/* sv/t0md_front.sv */
// Front part: stores bytes, checks the header and padding, queues one entry per message.
module t0md_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                frame_end,
   input  logic [3:0]          expected_major,
   input  logic                allow_extension,
   output logic                push,
   output t0md_pkg::entry_type push_entry
);
   logic [7:0] msg_ff [t0md_pkg::MsgBytes];
   logic [4:0] count_ff, count_in;
   logic [2:0] kind_ff, kind_in;
   logic [4:0] len_ff, len_in;
   logic [1:0] prio_ff, prio_in;
   logic       discard_ff, discard_in;
   logic [4:0] count_next;
   logic [t0md_pkg::MsgBits-1:0] snap;
   t0md_pkg::lookup_type look;

   assign count_next = count_ff + 5'd1;

   always_comb begin
      for (int i = 0; i < t0md_pkg::MsgBytes; i++) begin
         snap[t0md_pkg::MsgBits-1-8*i -: 8] =
            (count_ff == 5'(i)) ? data_byte : msg_ff[i];
      end
   end

   assign look = t0md_pkg::kind_lookup(msg_ff[0][3:0], data_byte[7:3]);

   always_comb begin
      count_in   = count_ff;
      kind_in    = kind_ff;
      len_in     = len_ff;
      prio_in    = prio_ff;
      discard_in = discard_ff;
      push       = 1'b0;
      push_entry.status = t0md_pkg::StTrunc;
      push_entry.kind   = kind_ff;
      push_entry.prio   = prio_ff;
      push_entry.len    = len_ff;
      push_entry.msg    = snap;
      if (accept) begin
         if (discard_ff) begin
            // drop trailing bytes up to the frame end
            if (frame_end) begin
               discard_in = 1'b0;
               count_in   = 5'd0;
            end
         end else if (count_ff == 5'd0) begin
            count_in = frame_end ? 5'd0 : 5'd1;
            if (frame_end) begin
               push = 1'b1;
               push_entry.kind = t0md_pkg::KindPresence;
               push_entry.prio = 2'd0;
            end
         end else if (count_ff == 5'd1) begin
            prio_in         = data_byte[2:1];
            push_entry.prio = data_byte[2:1];
            if ((data_byte[0] && !allow_extension) ||
                (msg_ff[0][7:4] != expected_major) || !look.found) begin
               push = 1'b1;
               push_entry.status = t0md_pkg::StUnsup;
               push_entry.kind   = t0md_pkg::KindPresence;
               count_in   = frame_end ? 5'd0 : 5'd2;
               discard_in = !frame_end;
            end else begin
               kind_in = look.kind;
               len_in  = t0md_pkg::kind_length(look.kind);
               push_entry.kind = look.kind;
               push = frame_end;
               count_in = frame_end ? 5'd0 : 5'd2;
            end
         end else if (count_next < len_ff) begin
            push     = frame_end;
            count_in = frame_end ? 5'd0 : count_next;
         end else begin
            // full message: check padding, then hand over
            push = 1'b1;
            push_entry.status = ((data_byte & t0md_pkg::pad_mask(kind_ff)) != 8'd0)
                                ? t0md_pkg::StNoncanon : t0md_pkg::StOk;
            count_in   = frame_end ? 5'd0 : count_next;
            discard_in = !frame_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !discard_ff && count_ff < 5'(t0md_pkg::MsgBytes)) begin
         msg_ff[count_ff] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         kind_ff    <= '0;
         len_ff     <= '0;
         prio_ff    <= '0;
         discard_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         kind_ff    <= kind_in;
         len_ff     <= len_in;
         prio_ff    <= prio_in;
         discard_ff <= discard_in;
      end
   end
endmodule

/* sv/t0md_back.sv */
// Back part: walks the fields of the queued message into the result register.
module t0md_back (
   input  logic                clock,
   input  logic                reset,
   input  t0md_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [47:0]         rsp_tdata,
   output logic                rsp_tlast
);
   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  prio_ff, prio_in;
   logic [3:0]  fnum_ff, fnum_in;
   logic [31:0] value_ff, value_in;
   logic [4:0]  cons_ff, cons_in;
   logic        last_ff, last_in;
   logic        advance, is_ok;
   logic [3:0]  nfields;

   assign is_ok   = (head.status == t0md_pkg::StOk);
   assign nfields = is_ok ? t0md_pkg::kind_fields(head.kind) : 4'd0;
   assign advance = !empty && (!valid_ff || rsp_tready);
   assign pop     = advance && (idx_ff == nfields);

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_tready;
      status_in = status_ff;
      kind_in   = kind_ff;
      prio_in   = prio_ff;
      fnum_in   = fnum_ff;
      value_in  = value_ff;
      cons_in   = cons_ff;
      last_in   = last_ff;
      if (advance) begin
         valid_in  = 1'b1;
         status_in = head.status;
         kind_in   = head.kind;
         prio_in   = head.prio;
         fnum_in   = idx_ff;
         value_in  = is_ok ? t0md_pkg::field_value(head.kind, idx_ff, head.msg) : 32'd0;
         cons_in   = is_ok ? head.len : 5'd0;
         last_in   = pop;
         idx_in    = pop ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      kind_ff   <= kind_in;
      prio_ff   <= prio_in;
      fnum_ff   <= fnum_in;
      value_ff  <= value_in;
      cons_ff   <= cons_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {cons_ff, value_ff, fnum_ff, prio_ff, kind_ff, status_ff};
   assign rsp_tlast  = last_ff;
endmodule

/* sv/tier0_message_decoder.sv */
// Top level of the framed message decoder.
//
// Input channel req_: one message byte per word, req_tlast marks the frame's last byte.
// Result channel rsp_: one word per decoded field, or a single error word per
// message; rsp_tlast marks the final word of a message.
// csr_: write expected major version (index 0) and extension allow (index 1)
// while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The front stores
// bytes, checks the header at byte 1 and the padding at the final byte, and pushes
// one entry per message into a four-deep queue. The back emits one field per
// cycle from the queue head unless rsp_tready stalls it. The byte that completes
// a message (or raises the error) queues its entry, then the result register takes it.
// The back holds a queue entry until its last word is out, so req_tready drops
// whenever the queue is full: when rsp_tready is held low, or when short error
// frames keep arriving while a nine-word message is still being emitted.
// Reset clears the byte count, discard flag, queue and result valid flag, and
// sets both configuration registers to zero.
// When the receiver stalls, the result word holds and the queue fills.
module tier0_message_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status, kind, priority_res, field_number,
                                    // field_value, consumed_bytes from bit 0 up
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [3:0]  csr_wdata
);
   logic [3:0] major_ff;
   logic       allow_ext_ff;
   logic       accept, push, pop, empty, full;
   t0md_pkg::entry_type push_entry, head;

   // hold configuration until rewritten
   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff     <= '0;
         allow_ext_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            t0md_pkg::CsrExpectedMajor:  major_ff     <= csr_wdata;
            t0md_pkg::CsrAllowExtension: allow_ext_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   t0md_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_tdata),
      .frame_end       (req_tlast),
      .expected_major  (major_ff),
      .allow_extension (allow_ext_ff),
      .push            (push),
      .push_entry      (push_entry)
   );

   t0md_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   t0md_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

/* sv/t0md_checker.sv */
// Port-level checks of the message decoder, bound to the top level.
`include "tier0_message_decoder_assert.svh"

module t0md_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);
   `T0MD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result word changed while stalled")
   `T0MD_ASSERT_NOW(a_err_single, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != t0md_pkg::StOk), rsp_tlast, "error word not final")
   `T0MD_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != t0md_pkg::StOk), (rsp_tdata[42:11] == 32'd0) && (rsp_tdata[47:43] == 5'd0), "error word carries data")
   `T0MD_ASSERT_NOW(a_ok_len, clock, reset, rsp_tvalid && (rsp_tdata[1:0] == t0md_pkg::StOk), (rsp_tdata[47:43] >= 5'd10) && (rsp_tdata[47:43] <= 5'd17), "bad consumed length")
endmodule

bind tier0_message_decoder t0md_checker u_t0md_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
